// ----- rtl/core/lpe_pkg.sv -----
// ============================================================================
// LSB payload extractor package
// Constants, phase codes and shared structures for the payload extractor.
// ============================================================================
package lpe_pkg;

    localparam int HeaderPixels = 11;
    localparam int BitsPerPixel = 3;
    localparam int BitsPerByte  = 8;
    localparam int LengthBits   = 32;

    localparam int HdrCountW = 4;
    localparam int BitCountW = 3;

    // Decoder phase codes. Code 3 is unused and behaves as done.
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic [7:0]            data;
        logic [LengthBits-1:0] index;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic [1:0]           phase;
        logic [HdrCountW-1:0] header_count;
    } t_status;

endpackage

// ----- rtl/core/lpe_decode.sv -----
// ============================================================================
// LSB payload extractor decoder
// Holds the header and byte packing state and decodes one accepted pixel per cycle.
// ============================================================================
module lpe_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_red_value,
    input  logic [7:0]      i_green_value,
    input  logic [7:0]      i_blue_value,
    input  logic            i_frame_start,
    output lpe_pkg::t_result o_result,
    output lpe_pkg::t_status o_status
);
    import lpe_pkg::*;

    logic [1:0]            r_phase, n_phase;
    logic [HdrCountW-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [LengthBits-1:0] r_length, n_length;
    logic [7:0]            r_acc, n_acc;
    logic [BitCountW-1:0]  r_bit_cnt, n_bit_cnt;
    logic [LengthBits-1:0] r_emitted, n_emitted;

    logic [1:0]            eff_phase;
    logic [HdrCountW-1:0]  eff_hdr_cnt;
    logic [LengthBits-1:0] eff_length;
    logic [7:0]            eff_acc;
    logic [BitCountW-1:0]  eff_bit_cnt;
    logic [LengthBits-1:0] eff_emitted;

    logic [BitsPerPixel-1:0] bits;
    logic [5:0]              hdr_base;
    logic [LengthBits-1:0]   hdr_vec;
    logic [HdrCountW-1:0]    hdr_inc;
    logic [10:0]             packed_bits;
    logic [BitCountW:0]      bit_sum;
    logic                    is_last;

    assign bits = {i_blue_value[0], i_green_value[0], i_red_value[0]};

    always_comb begin
        // A frame start clears everything before the pixel is decoded.
        if (i_frame_start) begin
            eff_phase   = PH_HEADER;
            eff_hdr_cnt = '0;
            eff_length  = '0;
            eff_acc     = '0;
            eff_bit_cnt = '0;
            eff_emitted = '0;
        end else begin
            eff_phase   = r_phase;
            eff_hdr_cnt = r_hdr_cnt;
            eff_length  = r_length;
            eff_acc     = r_acc;
            eff_bit_cnt = r_bit_cnt;
            eff_emitted = r_emitted;
        end

        hdr_base    = {2'b00, eff_hdr_cnt} * 6'(BitsPerPixel);
        // Header bit 32 shifts out of the top of the length field and is dropped.
        hdr_vec     = LengthBits'(bits) << hdr_base;
        hdr_inc     = eff_hdr_cnt + 4'd1;
        packed_bits = {3'b000, eff_acc} | (11'(bits) << eff_bit_cnt);
        bit_sum     = {1'b0, eff_bit_cnt} + 4'(BitsPerPixel);
        is_last     = (eff_emitted == (eff_length - 32'd1));

        n_phase   = eff_phase;
        n_hdr_cnt = eff_hdr_cnt;
        n_length  = eff_length;
        n_acc     = eff_acc;
        n_bit_cnt = eff_bit_cnt;
        n_emitted = eff_emitted;

        o_result.valid = 1'b0;
        o_result.data  = packed_bits[7:0];
        o_result.index = eff_emitted;
        o_result.last  = is_last;

        case (eff_phase)
            PH_HEADER: begin
                n_length  = eff_length | hdr_vec;
                n_hdr_cnt = hdr_inc;
                if (hdr_inc >= 4'(HeaderPixels)) begin
                    n_phase = (n_length == '0) ? PH_DONE : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (bit_sum >= 4'(BitsPerByte)) begin
                    o_result.valid = 1'b1;
                    n_emitted      = eff_emitted + 32'd1;
                    if (is_last) begin
                        // Leftover bits of this pixel are discarded.
                        n_phase   = PH_DONE;
                        n_acc     = '0;
                        n_bit_cnt = '0;
                    end else begin
                        n_acc     = {5'b00000, packed_bits[10:8]};
                        n_bit_cnt = 3'(bit_sum - 4'(BitsPerByte));
                    end
                end else begin
                    n_acc     = packed_bits[7:0];
                    n_bit_cnt = bit_sum[BitCountW-1:0];
                end
            end
            default: begin
                // Done: pixels are ignored until the next frame start.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_length  <= '0;
            r_acc     <= '0;
            r_bit_cnt <= '0;
            r_emitted <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_length  <= n_length;
            r_acc     <= n_acc;
            r_bit_cnt <= n_bit_cnt;
            r_emitted <= n_emitted;
        end
    end

    assign o_status.phase        = r_phase;
    assign o_status.header_count = r_hdr_cnt;

endmodule

// ----- rtl/core/lpe_out_reg.sv -----
// ============================================================================
// LSB payload extractor output register
// Holds one result transaction until the downstream side takes it.
// ============================================================================
module lpe_out_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  lpe_pkg::t_result                i_result,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [7:0]                      o_payload_byte,
    output logic [lpe_pkg::LengthBits-1:0]  o_byte_index,
    output logic                            o_last_byte
);
    import lpe_pkg::*;

    logic                  r_valid, n_valid;
    logic [7:0]            r_data;
    logic [LengthBits-1:0] r_index;
    logic                  r_last;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_result.valid;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_data  <= i_result.data;
            r_index <= i_result.index;
            r_last  <= i_result.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_data;
    assign o_byte_index   = r_index;
    assign o_last_byte    = r_last;

endmodule

// ----- rtl/core/lsb_payload_extractor_top.sv -----
// ============================================================================
// LSB payload extractor
// Recovers a byte payload hidden in the least significant bits of RGB pixels.
// ============================================================================
// The block takes one pixel transaction per cycle while not stalled; a
// payload byte appears at the output register in the cycle after the
// pixel that completes it. Each pixel contributes its red, green and blue
// least significant bits in that order. The first eleven pixels carry a
// 33-bit little-endian header whose low 32 bits give the payload length in
// bytes; the top header bit is dropped. The following bits are packed least
// significant bit first into bytes, each emitted with its index and a flag on
// the final byte. A zero length yields no bytes. Once the payload is complete,
// pixels are ignored until a pixel marked as frame start, which restarts
// decoding with that same pixel as the first header pixel. Decoding after
// reset starts in the header phase as if a frame start had been seen. The
// single output register sets the rate: the input stalls only while a result
// is held and the downstream side stalls it.
module lsb_payload_extractor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_red_value,
    input  logic [7:0]                      i_green_value,
    input  logic [7:0]                      i_blue_value,
    input  logic                            i_frame_start,
    // Payload byte output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_payload_byte,
    output logic [lpe_pkg::LengthBits-1:0]  o_byte_index,
    output logic                            o_last_byte
);
    import lpe_pkg::*;

    logic    in_accept;
    t_result result;
    t_status status;

    // The output register is free when empty or when its result is taken in
    // this cycle, so a new pixel can enter in every cycle of a flowing stream.
    assign o_in_stall = o_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    lpe_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_red_value   (i_red_value),
        .i_green_value (i_green_value),
        .i_blue_value  (i_blue_value),
        .i_frame_start (i_frame_start),
        .o_result      (result),
        .o_status      (status)
    );

    lpe_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_accept),
        .i_result       (result),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte)
    );

    // A header pixel never produces a payload byte.
    a_no_result_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_frame_start && status.phase == PH_HEADER) |-> !result.valid)
        else $error("payload byte produced during the header phase");

    // Once the final byte is produced, the decoder settles in the done phase.
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && result.valid && result.last) |=> (status.phase == PH_DONE))
        else $error("decoder not done after the final payload byte");

    // A freshly loaded result shows up at the output on the next cycle.
    a_result_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && result.valid) |=> (o_out_valid && o_byte_index == $past(result.index)))
        else $error("loaded result not presented at the output");

    // The header counter never runs past the header length while decoding it.
    a_header_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.phase == PH_HEADER) |-> (status.header_count < 4'(HeaderPixels)))
        else $error("header pixel count beyond header length");

endmodule
